>>> rtl/cpm_pkg.sv
// shared types and constants for the corner proximity merge block
// beat structs, command and register codes, register reset values
// no dependencies
package cpm_pkg;

	// table depth default
	localparam int TABLE_DEPTH_DEF = 256;

	// field widths
	localparam int COORD_W = 16;
	localparam int CMD_W = 2;
	localparam int MAXP_W = 12;
	localparam int MIND_W = 8;
	localparam int MERGED_W = 12;

	// configuration port
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_POINTS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 1'd1;

	// register reset values
	localparam logic [MAXP_W-1:0] MAX_POINTS_RST = 12'd512;
	localparam logic [MIND_W-1:0] MIN_DISTANCE_RST = 8'd48;

	// merged count saturation value
	localparam logic [MERGED_W-1:0] MERGED_MAX = '1;

	// command codes
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TRACK = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CORNER = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [COORD_W-1:0] in_x;
		logic [COORD_W-1:0] in_y;
		logic               in_landmark;
	} in_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] out_x;
		logic [COORD_W-1:0] out_y;
		logic               out_landmark;
		logic               from_detector;
		logic               table_overflow;
	} out_item_t;

endpackage

>>> rtl/corner_proximity_merge.sv
// a clear resets the counts and gives no result; a tracked point, a landmark corner
// or a corner on an empty table goes to S_EMIT; a scanned corner reads one table
// entry per cycle in S_SCAN, paced by the single table read port, and is dropped
// if too close; a new beat is taken only in S_IDLE; a stalled output beat holds S_EMIT
// reset: counts, configuration (max_points 512, min_distance 48) and valids clear at once;
// the point table holds no reset and only entries below the tracked count are compared
module corner_proximity_merge #(
	parameter int TABLE_DEPTH = cpm_pkg::TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  cpm_pkg::in_item_t                 in_data,
	// output channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output cpm_pkg::out_item_t                out_data,
	// configuration write port
	input  logic                              cfg_wr_en,
	input  logic [cpm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cpm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int DIST_W = cpm_pkg::COORD_W + 1;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_t;

	state_t                             state_q;
	logic [CNT_W-1:0]                   tracked_q;
	logic [cpm_pkg::MERGED_W-1:0]       merged_q;
	logic [cpm_pkg::MAXP_W-1:0]         max_points_q;
	logic [cpm_pkg::MIND_W-1:0]         min_dist_q;
	logic [CNT_W-1:0]                   scan_cnt_q;
	logic                               chk_q;
	logic [cpm_pkg::COORD_W-1:0]        cx_q;
	logic [cpm_pkg::COORD_W-1:0]        cy_q;
	cpm_pkg::out_item_t                 res_q;
	cpm_pkg::out_item_t                 out_q;
	logic                               out_valid_q;

	// point table, x in the upper half
	logic [2*cpm_pkg::COORD_W-1:0]      table_mem [TABLE_DEPTH];
	logic [2*cpm_pkg::COORD_W-1:0]      rd_data_q;
	logic [IDX_W-1:0]                   rd_addr;
	logic                               wr_en;

	logic                               in_fire;
	logic                               slot_free;
	logic                               table_full;
	logic [cpm_pkg::MERGED_W-1:0]       merged_inc;
	logic [cpm_pkg::COORD_W-1:0]        ex, ey, dx, dy;
	logic [DIST_W-1:0]                  gap_sum;
	logic                               too_close;

	assign in_ready   = (state_q == S_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign slot_free  = !out_valid_q || out_ready;
	assign table_full = (tracked_q >= CNT_W'(TABLE_DEPTH));
	assign merged_inc = (merged_q == cpm_pkg::MERGED_MAX) ? merged_q
		: merged_q + cpm_pkg::MERGED_W'(1);
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	// table write on a tracked beat with room left
	assign wr_en = in_fire && (in_data.command == cpm_pkg::CMD_TRACK) && !table_full;

	// entry zero is read while idle so a scan starts at once
	assign rd_addr = (state_q == S_SCAN) ? scan_cnt_q[IDX_W-1:0] : '0;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[tracked_q[IDX_W-1:0]] <= {in_data.in_x, in_data.in_y};
		end
		rd_data_q <= table_mem[rd_addr];
	end

	// manhattan distance of the held corner to the entry just read
	always_comb begin
		ex = rd_data_q[2*cpm_pkg::COORD_W-1:cpm_pkg::COORD_W];
		ey = rd_data_q[cpm_pkg::COORD_W-1:0];
		dx = (cx_q > ex) ? (cx_q - ex) : (ex - cx_q);
		dy = (cy_q > ey) ? (cy_q - ey) : (ey - cy_q);
		gap_sum = DIST_W'(dx) + DIST_W'(dy);
		too_close = gap_sum < DIST_W'(min_dist_q);
	end

	// control, counters, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			tracked_q    <= '0;
			merged_q     <= '0;
			max_points_q <= cpm_pkg::MAX_POINTS_RST;
			min_dist_q   <= cpm_pkg::MIN_DISTANCE_RST;
			scan_cnt_q   <= '0;
			chk_q        <= 1'b0;
			cx_q         <= '0;
			cy_q         <= '0;
			res_q        <= '0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// output beat loaded or taken downstream
			if ((state_q == S_EMIT) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			// register writes
			if (cfg_wr_en) begin
				case (cfg_index)
					cpm_pkg::REG_MAX_POINTS: begin
						max_points_q <= cfg_data[cpm_pkg::MAXP_W-1:0];
					end
					cpm_pkg::REG_MIN_DISTANCE: begin
						min_dist_q <= cfg_data[cpm_pkg::MIND_W-1:0];
					end
					default: begin
					end
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						case (in_data.command)
							cpm_pkg::CMD_CLEAR: begin
								tracked_q <= '0;
								merged_q  <= '0;
							end
							cpm_pkg::CMD_TRACK: begin
								if (!table_full) begin
									tracked_q <= tracked_q + CNT_W'(1);
								end
								merged_q <= merged_inc;
								res_q    <= '{out_x: in_data.in_x, out_y: in_data.in_y,
									out_landmark: in_data.in_landmark, from_detector: 1'b0,
									table_overflow: table_full};
								state_q  <= S_EMIT;
							end
							cpm_pkg::CMD_CORNER: begin
								cx_q  <= in_data.in_x;
								cy_q  <= in_data.in_y;
								res_q <= '{out_x: in_data.in_x, out_y: in_data.in_y,
									out_landmark: in_data.in_landmark, from_detector: 1'b1,
									table_overflow: 1'b0};
								if (merged_q < max_points_q) begin
									if (in_data.in_landmark || (tracked_q == '0)) begin
										merged_q <= merged_inc;
										state_q  <= S_EMIT;
									end else begin
										// entry zero is being read now
										scan_cnt_q <= CNT_W'(1);
										chk_q      <= 1'b1;
										state_q    <= S_SCAN;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (chk_q && too_close) begin
						// rejected corner, no result
						chk_q   <= 1'b0;
						state_q <= S_IDLE;
					end else if (!chk_q) begin
						// every stored point far enough
						merged_q <= merged_inc;
						state_q  <= S_EMIT;
					end else begin
						chk_q <= (scan_cnt_q < tracked_q);
						if (scan_cnt_q < tracked_q) begin
							scan_cnt_q <= scan_cnt_q + CNT_W'(1);
						end
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/cpm_checker.sv
// port-level checks for the corner proximity merge block
// uses cpm_pkg command codes and beat structs; bound to corner_proximity_merge
module cpm_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input cpm_pkg::in_item_t    in_data,
	input logic                 out_valid,
	input logic                 out_ready,
	input cpm_pkg::out_item_t   out_data
);

	logic in_fire;
	assign in_fire = in_valid && in_ready;

	// stalled output beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// a detected corner never carries the overflow flag
	a_corner_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.from_detector |-> !out_data.table_overflow)
		else $error("overflow flag on a detected corner");

	// a clear beat taken with the output empty yields no result
	a_clear_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (in_data.command == cpm_pkg::CMD_CLEAR) && !out_valid |=> !out_valid)
		else $error("result after a clear beat");

	// a tracked point taken with the output free holds off the input in S_EMIT and then comes out
	a_track_passes: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (in_data.command == cpm_pkg::CMD_TRACK) && !out_valid
		|=> !in_ready ##1 (out_valid && !out_data.from_detector))
		else $error("tracked point not passed out");

endmodule

bind corner_proximity_merge cpm_checker u_cpm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
